FILE: hw/rtl/kwm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kwm_pkg
// Types and constants shared by the k-mer window minimizer.
// ----------------------------------------------------------------------------
package kwm_pkg;

  localparam int unsigned KmerW    = 32;
  localparam int unsigned PosW     = 32;
  localparam int unsigned KLenW    = 5;
  localparam int unsigned KMax     = 16;
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 5;

  // configuration register indexes
  localparam logic [CfgIdxW-1:0] REG_KMER_LENGTH   = 2'd0;
  localparam logic [CfgIdxW-1:0] REG_WINDOW_LENGTH = 2'd1;
  localparam logic [CfgIdxW-1:0] REG_STRAND_FLAG   = 2'd2;

  localparam logic [KLenW-1:0] KmerLenReset   = 5'd15;
  localparam logic [KLenW-1:0] WindowLenReset = 5'd10;
  localparam logic             StrandReset    = 1'b1;

  // nucleotide codes
  localparam logic [1:0] BASE_A = 2'd0;
  localparam logic [1:0] BASE_C = 2'd1;
  localparam logic [1:0] BASE_G = 2'd2;
  localparam logic [1:0] BASE_T = 2'd3;

  typedef struct packed {
    logic [KmerW-1:0] value;
    logic [PosW-1:0]  position;
  } kwm_entry_t;

  typedef struct packed {
    logic       valid;
    kwm_entry_t entry;
  } kwm_scan_t;

  typedef struct packed {
    logic pop;
    logic push;
  } kwm_win_ctrl_t;

  typedef struct packed {
    logic [KmerW-1:0] minimizer_value;
    logic [PosW-1:0]  kmer_position;
    logic             strand_out;
    logic             run_end;
  } kwm_result_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DROP,
    ST_PUSH,
    ST_RESCAN,
    ST_TAIL,
    ST_FLUSH
  } kwm_state_e;

endpackage

FILE: hw/rtl/kwm_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kwm_if
// Handshake channels of the k-mer window minimizer.
// ----------------------------------------------------------------------------
interface kwm_base_if;
  import kwm_pkg::*;
  logic       valid;
  logic       ready;
  logic [1:0] base_code;
  logic       final_base;
  modport source (output valid, base_code, final_base, input ready);
  modport sink (input valid, base_code, final_base, output ready);
endinterface

interface kwm_result_if;
  import kwm_pkg::*;
  logic             valid;
  logic             ready;
  logic [KmerW-1:0] minimizer_value;
  logic [PosW-1:0]  kmer_position;
  logic             strand_out;
  logic             run_end;
  modport source (output valid, minimizer_value, kmer_position, strand_out, run_end,
                  input ready);
  modport sink (input valid, minimizer_value, kmer_position, strand_out, run_end,
                output ready);
endinterface

interface kwm_cfg_if;
  import kwm_pkg::*;
  logic                valid;
  logic                ready;
  logic [CfgIdxW-1:0]  index;
  logic [CfgDataW-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

FILE: hw/rtl/kwm_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kwm_cell
// One window slot: holds a k-mer and its position, shifts toward the head on
// a pop, and passes a running minimum to the next slot every cycle.
// ----------------------------------------------------------------------------
module kwm_cell (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               shift_i,
  input  logic               load_i,
  input  logic               valid_i,
  input  kwm_pkg::kwm_entry_t next_i,
  input  kwm_pkg::kwm_entry_t new_i,
  input  kwm_pkg::kwm_scan_t  scan_i,
  output kwm_pkg::kwm_entry_t entry_o,
  output kwm_pkg::kwm_scan_t  scan_o
);
  import kwm_pkg::*;

  kwm_entry_t entry_q, entry_d;
  kwm_scan_t  scan_q, scan_d;
  logic       in_wins;

  always_comb begin
    entry_d = entry_q;
    if (load_i) begin
      entry_d = new_i;
    end else if (shift_i) begin
      entry_d = next_i;
    end
  end

  // older slots sit upstream, so the incoming minimum keeps ties
  assign in_wins = scan_i.valid && (!valid_i || (scan_i.entry.value <= entry_q.value));

  always_comb begin
    if (in_wins || !valid_i) begin
      scan_d = scan_i;
    end else begin
      scan_d.valid = 1'b1;
      scan_d.entry = entry_q;
    end
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scan_q <= '0;
    end else begin
      scan_q <= scan_d;
    end
  end

  assign entry_o = entry_q;
  assign scan_o  = scan_q;

endmodule

FILE: hw/rtl/kwm_window.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kwm_window
// Row of window cells, oldest k-mer in cell 0, with the minimum scan chain.
// ----------------------------------------------------------------------------
module kwm_window #(
  parameter int unsigned WINDOW_MAX = 16
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  kwm_pkg::kwm_win_ctrl_t          ctrl_i,
  input  logic [$clog2(WINDOW_MAX+1)-1:0] fill_i,
  input  kwm_pkg::kwm_entry_t             new_i,
  output kwm_pkg::kwm_entry_t             head_o,
  output kwm_pkg::kwm_scan_t              min_o
);
  import kwm_pkg::*;

  localparam int unsigned CntW = $clog2(WINDOW_MAX + 1);

  kwm_entry_t entries [WINDOW_MAX];
  kwm_scan_t  chain [WINDOW_MAX+1];

  assign chain[0] = '0;

  for (genvar i = 0; i < WINDOW_MAX; i++) begin : g_cell
    kwm_entry_t next_entry;
    if (i == WINDOW_MAX - 1) begin : g_last
      assign next_entry = entries[i];
    end else begin : g_mid
      assign next_entry = entries[i+1];
    end

    kwm_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .shift_i (ctrl_i.pop),
      .load_i  (ctrl_i.push && (fill_i == CntW'(i))),
      .valid_i (CntW'(i) < fill_i),
      .next_i  (next_entry),
      .new_i   (new_i),
      .scan_i  (chain[i]),
      .entry_o (entries[i]),
      .scan_o  (chain[i+1])
    );
  end

  assign head_o = entries[0];
  assign min_o  = chain[WINDOW_MAX];

endmodule

FILE: hw/rtl/kmer_window_minimizer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kmer_window_minimizer
// Streaming DNA minimizer: rolling k-mer, sliding window of cells, minimum
// tracking and tail shrink at the end of each sequence.
// ----------------------------------------------------------------------------
//   port        dir   items
//   base_in     in    one base: base_code, final_base
//   result_out  out   one minimizer: minimizer_value, kmer_position, strand_out, run_end
//   cfg_wr      in    register write: index, data (always ready)
//
// One base at a time. Each item is accepted in the idle state; with a k-mer, entries
// are dropped from the window until it is below the window length, then the k-mer
// is pushed, and each rescan of the cell row lets the minimum walk down the chain;
// on the final base the tail is popped; an end state closes each item.
// Reset leaves the window empty and loads register defaults (k 15, w 10, strand 1).
// A full output register stalls the sequencer only when a second result waits.
// ----------------------------------------------------------------------------
module kmer_window_minimizer #(
  parameter int unsigned WINDOW_MAX = 16
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  kwm_base_if.sink     base_in,
  kwm_result_if.source result_out,
  kwm_cfg_if.sink      cfg_wr
);
  import kwm_pkg::*;

  localparam int unsigned CntW = $clog2(WINDOW_MAX + 1);

  // configuration
  logic [KLenW-1:0] kmer_len_q, window_len_q;
  logic             strand_q;

  // sequencer state
  kwm_state_e       state_q, state_d;
  logic [KmerW-1:0] kmer_q, kmer_d;
  logic [PosW-1:0]  seen_q, seen_d;
  logic [CntW-1:0]  fill_q, fill_d;
  logic [CntW-1:0]  scan_cnt_q, scan_cnt_d;
  logic [KLenW-1:0] tail_cnt_q, tail_cnt_d;
  kwm_entry_t       best_q, best_d;
  kwm_entry_t       new_q, new_d;
  logic             hit_q, hit_d;
  logic             fin_q, fin_d;
  logic             first_q, first_d;
  logic             tail_q, tail_d;

  // result staging
  logic             pend_valid_q, pend_valid_d;
  kwm_entry_t       pend_q, pend_d;
  logic             out_valid_q, out_valid_d;
  kwm_result_t      out_q, out_d;

  // window
  kwm_win_ctrl_t    win_ctrl;
  kwm_entry_t       head;
  kwm_scan_t        win_min;

  logic             emit;
  kwm_entry_t       emit_entry;
  logic             flush_out;

  logic [KLenW-1:0] k_eff;
  logic [CntW-1:0]  w_eff;
  logic [5:0]       mask_shamt;
  logic [KmerW-1:0] mask;
  logic [KmerW-1:0] kmer_next;
  logic [PosW-1:0]  seen_next;
  logic [PosW-1:0]  pos_next;
  logic             has_kmer;
  logic             in_accept;
  logic             ge_w;
  logic             hit_head;
  logic             out_free;
  logic             can_emit;
  logic             tail_done;
  logic             scan_done;
  logic             pop_keeps;

  // ---------------------------------------------------------------- config
  assign cfg_wr.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kmer_len_q   <= KmerLenReset;
      window_len_q <= WindowLenReset;
      strand_q     <= StrandReset;
    end else if (cfg_wr.valid) begin
      case (cfg_wr.index)
        REG_KMER_LENGTH:   kmer_len_q   <= cfg_wr.data;
        REG_WINDOW_LENGTH: window_len_q <= cfg_wr.data;
        REG_STRAND_FLAG:   strand_q     <= cfg_wr.data[0];
        default: ;
      endcase
    end
  end

  // ----------------------------------------------------------- derived values
  always_comb begin
    if (kmer_len_q == '0) begin
      k_eff = KLenW'(1);
    end else if (kmer_len_q > KLenW'(KMax)) begin
      k_eff = KLenW'(KMax);
    end else begin
      k_eff = kmer_len_q;
    end
  end

  always_comb begin
    if (window_len_q == '0) begin
      w_eff = CntW'(1);
    end else if (int'(window_len_q) > int'(WINDOW_MAX)) begin
      w_eff = CntW'(WINDOW_MAX);
    end else begin
      w_eff = CntW'(window_len_q);
    end
  end

  // keep the low k-1 bases: all ones shifted right by 34-2k
  assign mask_shamt = 6'd34 - {k_eff, 1'b0};
  assign mask       = {KmerW{1'b1}} >> mask_shamt;
  assign kmer_next  = ((kmer_q & mask) << 2) | {{(KmerW-2){1'b0}}, base_in.base_code};
  assign seen_next  = (seen_q == '1) ? seen_q : seen_q + PosW'(1);
  assign has_kmer   = seen_next >= PosW'(k_eff);
  assign pos_next   = seen_next - PosW'(k_eff) + PosW'(1);

  assign in_accept  = base_in.valid && base_in.ready;
  assign ge_w       = fill_q >= w_eff;
  assign hit_head   = (head.value == best_q.value) && (head.position == best_q.position);
  assign out_free   = !out_valid_q || result_out.ready;
  assign can_emit   = !pend_valid_q || out_free;
  assign tail_done  = (tail_cnt_q == k_eff - KLenW'(1)) || (fill_q == '0);
  assign scan_done  = scan_cnt_q == CntW'(WINDOW_MAX);
  assign pop_keeps  = fill_q > CntW'(1);

  assign base_in.ready = (state_q == ST_IDLE);

  // ------------------------------------------------------------- next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_accept) begin
          if (has_kmer) begin
            state_d = ST_DROP;
          end else begin
            state_d = base_in.final_base ? ST_TAIL : ST_FLUSH;
          end
        end
      end
      ST_DROP: begin
        if (!ge_w) begin
          state_d = ST_PUSH;
        end
      end
      ST_PUSH: begin
        if (can_emit) begin
          if (!first_q && hit_q) begin
            state_d = ST_RESCAN;
          end else begin
            state_d = fin_q ? ST_TAIL : ST_FLUSH;
          end
        end
      end
      ST_RESCAN: begin
        if (scan_done && can_emit) begin
          state_d = (tail_q || fin_q) ? ST_TAIL : ST_FLUSH;
        end
      end
      ST_TAIL: begin
        if (tail_done) begin
          state_d = ST_FLUSH;
        end else if (hit_head && pop_keeps) begin
          state_d = ST_RESCAN;
        end
      end
      ST_FLUSH: begin
        if (!pend_valid_q || out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // ------------------------------------------------------- sequencer actions
  always_comb begin
    kmer_d     = kmer_q;
    seen_d     = seen_q;
    fill_d     = fill_q;
    scan_cnt_d = scan_cnt_q;
    tail_cnt_d = tail_cnt_q;
    best_d     = best_q;
    new_d      = new_q;
    hit_d      = hit_q;
    fin_d      = fin_q;
    first_d    = first_q;
    tail_d     = tail_q;
    win_ctrl   = '0;
    emit       = 1'b0;
    emit_entry = new_q;
    flush_out  = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (in_accept) begin
          kmer_d         = kmer_next;
          seen_d         = seen_next;
          new_d.value    = kmer_next;
          new_d.position = pos_next;
          fin_d          = base_in.final_base;
          first_d        = (fill_q == '0);
          hit_d          = 1'b0;
          tail_d         = 1'b0;
          tail_cnt_d     = '0;
        end
      end
      ST_DROP: begin
        if (ge_w) begin
          win_ctrl.pop = 1'b1;
          fill_d       = fill_q - CntW'(1);
          hit_d        = hit_q || hit_head;
        end
      end
      ST_PUSH: begin
        if (can_emit) begin
          win_ctrl.push = 1'b1;
          fill_d        = fill_q + CntW'(1);
          if (first_q) begin
            best_d = new_q;
            emit   = 1'b1;
          end else if (hit_q) begin
            scan_cnt_d = '0;
          end else if (new_q.value < best_q.value) begin
            best_d = new_q;
            emit   = 1'b1;
          end
        end
      end
      ST_RESCAN: begin
        if (!scan_done) begin
          scan_cnt_d = scan_cnt_q + CntW'(1);
        end else if (can_emit) begin
          best_d     = win_min.entry;
          emit       = 1'b1;
          emit_entry = win_min.entry;
        end
      end
      ST_TAIL: begin
        if (!tail_done) begin
          win_ctrl.pop = 1'b1;
          fill_d       = fill_q - CntW'(1);
          tail_cnt_d   = tail_cnt_q + KLenW'(1);
          if (hit_head && pop_keeps) begin
            scan_cnt_d = '0;
            tail_d     = 1'b1;
          end
        end
      end
      ST_FLUSH: begin
        if (!pend_valid_q || out_free) begin
          flush_out = pend_valid_q;
          if (fin_q) begin
            kmer_d = '0;
            seen_d = '0;
            fill_d = '0;
          end
        end
      end
      default: ;
    endcase
  end

  // the newest result waits in pend until we know whether it closes the item
  always_comb begin
    out_valid_d  = out_valid_q && !result_out.ready;
    out_d        = out_q;
    pend_valid_d = pend_valid_q;
    pend_d       = pend_q;
    if ((emit && pend_valid_q) || flush_out) begin
      out_valid_d           = 1'b1;
      out_d.minimizer_value = pend_q.value;
      out_d.kmer_position   = pend_q.position;
      out_d.strand_out      = strand_q;
      out_d.run_end         = flush_out;
    end
    if (emit) begin
      pend_valid_d = 1'b1;
      pend_d       = emit_entry;
    end else if (flush_out) begin
      pend_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      kmer_q       <= '0;
      seen_q       <= '0;
      fill_q       <= '0;
      scan_cnt_q   <= '0;
      tail_cnt_q   <= '0;
      best_q       <= '0;
      hit_q        <= 1'b0;
      fin_q        <= 1'b0;
      first_q      <= 1'b0;
      tail_q       <= 1'b0;
      pend_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      kmer_q       <= kmer_d;
      seen_q       <= seen_d;
      fill_q       <= fill_d;
      scan_cnt_q   <= scan_cnt_d;
      tail_cnt_q   <= tail_cnt_d;
      best_q       <= best_d;
      hit_q        <= hit_d;
      fin_q        <= fin_d;
      first_q      <= first_d;
      tail_q       <= tail_d;
      pend_valid_q <= pend_valid_d;
      out_valid_q  <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    new_q  <= new_d;
    pend_q <= pend_d;
    out_q  <= out_d;
  end

  // ------------------------------------------------------------------ window
  kwm_window #(
    .WINDOW_MAX (WINDOW_MAX)
  ) u_window (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (win_ctrl),
    .fill_i (fill_q),
    .new_i  (new_q),
    .head_o (head),
    .min_o  (win_min)
  );

  assign result_out.valid           = out_valid_q;
  assign result_out.minimizer_value = out_q.minimizer_value;
  assign result_out.kmer_position   = out_q.kmer_position;
  assign result_out.strand_out      = out_q.strand_out;
  assign result_out.run_end         = out_q.run_end;

endmodule

FILE: tb/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives DNA bases into kmer_window_minimizer and checks every minimizer it
// emits against a cycle-free model of the rolling k-mer, window and tail
// shrink, over several register settings and handshake idle patterns.
// ----------------------------------------------------------------------------
module testbench;
  import kwm_pkg::*;

  localparam int unsigned SettleCycles  = 400;
  localparam int unsigned WatchdogLimit = 4000;
  localparam int unsigned WinCells      = 16;
  // index with no register behind it
  localparam logic [CfgIdxW-1:0] REG_UNUSED = 2'd3;

  typedef enum int {
    IDLE_SEND_LIGHT,
    IDLE_SEND_HEAVY,
    IDLE_NONE
  } idle_mode_e;

  // expected minimizers, in emission order
  class minimizer_board;
    logic [KLenW-1:0] k_reg;
    logic [KLenW-1:0] w_reg;
    logic             strand_reg;
    logic [31:0]      rolling;
    logic [31:0]      seen;
    logic [31:0]      win_val[WinCells];
    logic [31:0]      win_pos[WinCells];
    int unsigned      fill;
    logic [31:0]      best_val;
    logic [31:0]      best_pos;
    kwm_result_t      pending[$];
    kwm_result_t      held;
    bit               have_held;
    int unsigned      fails;

    function new();
      k_reg      = KmerLenReset;
      w_reg      = WindowLenReset;
      strand_reg = StrandReset;
      rolling    = '0;
      seen       = '0;
      fill       = 0;
      best_val   = '0;
      best_pos   = '0;
      have_held  = 1'b0;
      fails      = 0;
    endfunction

    function int unsigned pending_count();
      return pending.size();
    endfunction

    function void write_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] val);
      case (idx)
        REG_KMER_LENGTH:   k_reg = val;
        REG_WINDOW_LENGTH: w_reg = val;
        REG_STRAND_FLAG:   strand_reg = val[0];
        default: ;
      endcase
    endfunction

    function bit drop_oldest();
      bit hit;
      if (fill == 0) return 1'b0;
      hit = (win_val[0] == best_val) && (win_pos[0] == best_pos);
      for (int i = 1; i < fill; i++) begin
        win_val[i-1] = win_val[i];
        win_pos[i-1] = win_pos[i];
      end
      fill--;
      return hit;
    endfunction

    function void add_newest(logic [31:0] v, logic [31:0] p);
      if (fill >= WinCells) return;
      win_val[fill] = v;
      win_pos[fill] = p;
      fill++;
    endfunction

    // strict compare keeps the earliest entry on equal values
    function void rescan();
      if (fill == 0) return;
      best_val = win_val[0];
      best_pos = win_pos[0];
      for (int i = 1; i < fill; i++) begin
        if (win_val[i] < best_val) begin
          best_val = win_val[i];
          best_pos = win_pos[i];
        end
      end
    endfunction

    // last result of a step is held back so run_end can be set on it
    function void emit_best();
      if (have_held) pending = {pending, held};
      held.minimizer_value = best_val;
      held.kmer_position   = best_pos;
      held.strand_out      = strand_reg;
      held.run_end         = 1'b0;
      have_held            = 1'b1;
    endfunction

    function void note_base(logic [1:0] b, logic fin);
      int unsigned kc;
      int unsigned wc;
      logic [31:0] mask;
      logic [31:0] pos;
      bit          hit;
      kc = (k_reg < 1) ? 1 : ((k_reg > 16) ? 16 : k_reg);
      wc = (w_reg < 1) ? 1 : ((w_reg > WinCells) ? WinCells : w_reg);
      mask = (kc == 1) ? 32'd0 : ((32'd1 << (2 * (kc - 1))) - 32'd1);
      rolling = ((rolling & mask) << 2) | 32'(b);
      if (seen != '1) seen++;
      if (seen >= kc) begin
        pos = seen - kc + 1;
        if (fill == 0) begin
          add_newest(rolling, pos);
          best_val = rolling;
          best_pos = pos;
          emit_best();
        end else begin
          hit = 1'b0;
          while (fill >= wc) begin
            if (drop_oldest()) hit = 1'b1;
          end
          add_newest(rolling, pos);
          if (hit) begin
            rescan();
            emit_best();
          end else if (rolling < best_val) begin
            best_val = rolling;
            best_pos = pos;
            emit_best();
          end
        end
      end
      if (fin) begin
        for (int t = 0; t + 1 < kc; t++) begin
          if (fill == 0) break;
          hit = drop_oldest();
          if (hit && fill > 0) begin
            rescan();
            emit_best();
          end
        end
        rolling = '0;
        seen    = '0;
        fill    = 0;
      end
      if (have_held) begin
        held.run_end = 1'b1;
        pending = {pending, held};
        have_held = 1'b0;
      end
    endfunction

    function void check_result(kwm_result_t got);
      kwm_result_t want;
      if (pending.size() == 0) begin
        $display("%0t: unexpected minimizer value %h position %h", $time,
                 got.minimizer_value, got.kmer_position);
        fails++;
        return;
      end
      want = pending.pop_front();
      if (got.minimizer_value !== want.minimizer_value) begin
        $display("%0t: minimizer_value expected %h got %h", $time,
                 want.minimizer_value, got.minimizer_value);
        fails++;
      end
      if (got.kmer_position !== want.kmer_position) begin
        $display("%0t: kmer_position expected %h got %h", $time,
                 want.kmer_position, got.kmer_position);
        fails++;
      end
      if (got.strand_out !== want.strand_out) begin
        $display("%0t: strand_out expected %b got %b", $time,
                 want.strand_out, got.strand_out);
        fails++;
      end
      if (got.run_end !== want.run_end) begin
        $display("%0t: run_end expected %b got %b", $time,
                 want.run_end, got.run_end);
        fails++;
      end
    endfunction
  endclass

  logic clk_i;
  logic rst_ni;

  kwm_base_if   base_ch ();
  kwm_result_if res_ch ();
  kwm_cfg_if    cfg_ch ();

  kmer_window_minimizer #(
    .WINDOW_MAX(WinCells)
  ) u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .base_in    (base_ch),
    .result_out (res_ch),
    .cfg_wr     (cfg_ch)
  );

  minimizer_board board;
  kwm_result_t    mon_result;
  int unsigned    send_idle_pct;
  int unsigned    recv_idle_pct;
  int unsigned    quiet_cycles;

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  initial begin
    res_ch.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      res_ch.ready <= rst_ni && ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // monitor and watchdog
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (res_ch.valid && res_ch.ready) begin
        mon_result.minimizer_value = res_ch.minimizer_value;
        mon_result.kmer_position   = res_ch.kmer_position;
        mon_result.strand_out      = res_ch.strand_out;
        mon_result.run_end         = res_ch.run_end;
        board.check_result(mon_result);
      end
      if (base_ch.valid && base_ch.ready)
        board.note_base(base_ch.base_code, base_ch.final_base);
      if (cfg_ch.valid && cfg_ch.ready)
        board.write_reg(cfg_ch.index, cfg_ch.data);
      if ((res_ch.valid && res_ch.ready) || (base_ch.valid && base_ch.ready) ||
          (cfg_ch.valid && cfg_ch.ready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
      if (quiet_cycles >= WatchdogLimit) begin
        $display("%0t: watchdog expired", $time);
        $display("end of test: mismatches");
        $finish;
      end
    end
  end

  task automatic set_idling(input idle_mode_e mode);
    case (mode)
      IDLE_SEND_LIGHT: begin
        send_idle_pct = 20;
        recv_idle_pct = 74;
      end
      IDLE_SEND_HEAVY: begin
        send_idle_pct = 74;
        recv_idle_pct = 20;
      end
      default: begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
    endcase
  endtask

  task automatic send_base(input logic [1:0] b, input logic fin);
    while ($urandom_range(99) < send_idle_pct) begin
      @(negedge clk_i);
      base_ch.valid <= 1'b0;
    end
    @(negedge clk_i);
    base_ch.valid      <= 1'b1;
    base_ch.base_code  <= b;
    base_ch.final_base <= fin;
    do @(posedge clk_i); while (!base_ch.ready);
  endtask

  // sender stops until every expected minimizer has come out
  task automatic hold_off();
    @(negedge clk_i);
    base_ch.valid <= 1'b0;
    while (board.pending_count() != 0) @(posedge clk_i);
  endtask

  task automatic settle();
    hold_off();
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic write_cfg(input logic [CfgIdxW-1:0] idx,
                           input logic [CfgDataW-1:0] val);
    @(negedge clk_i);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= val;
    do @(posedge clk_i); while (!cfg_ch.ready);
    @(negedge clk_i);
    cfg_ch.valid <= 1'b0;
  endtask

  task automatic program_regs(input logic [KLenW-1:0] k, input logic [KLenW-1:0] w,
                              input logic s);
    write_cfg(REG_KMER_LENGTH, k);
    write_cfg(REG_WINDOW_LENGTH, w);
    // upper data bits are don't-care for the strand register
    write_cfg(REG_STRAND_FLAG, {4'($urandom_range(15)), s});
  endtask

  // mostly full-length sequences, some short ones; a phase may end
  // mid-sequence so the next setting picks it up
  task automatic run_random(input logic [KLenW-1:0] k, input logic [KLenW-1:0] w,
                            input logic s, input idle_mode_e mode,
                            input int unsigned n_items, input int unsigned pause_at);
    int unsigned kc;
    int unsigned wc;
    int unsigned seq_len;
    int unsigned sent;
    bit          low_entropy;
    logic [1:0]  b;
    settle();
    program_regs(k, w, s);
    set_idling(mode);
    kc = (k < 1) ? 1 : ((k > 16) ? 16 : k);
    wc = (w < 1) ? 1 : ((w > WinCells) ? WinCells : w);
    sent = 0;
    while (sent < n_items) begin
      if ($urandom_range(99) < 20)
        seq_len = $urandom_range(1, (wc + kc > 2) ? wc + kc - 2 : 1);
      else
        seq_len = $urandom_range(wc + kc - 1, wc + kc + 6);
      // A/C only runs make repeated k-mers and value ties likely
      low_entropy = ($urandom_range(99) < 30);
      for (int i = 0; i < seq_len && sent < n_items; i++) begin
        b = low_entropy ? 2'($urandom_range(1)) : 2'($urandom_range(3));
        send_base(b, i == seq_len - 1);
        sent++;
        if (sent == pause_at) hold_off();
      end
    end
  endtask

  initial begin
    board              = new();
    quiet_cycles       = 0;
    send_idle_pct      = 0;
    recv_idle_pct      = 0;
    base_ch.valid      = 1'b0;
    base_ch.base_code  = BASE_A;
    base_ch.final_base = 1'b0;
    cfg_ch.valid       = 1'b0;
    cfg_ch.index       = REG_KMER_LENGTH;
    cfg_ch.data        = '0;
    rst_ni             = 1'b0;
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // directed: short sequences at reset settings give no k-mer
    set_idling(IDLE_SEND_LIGHT);
    send_base(BASE_T, 1'b1);
    send_base(BASE_A, 1'b0);
    send_base(BASE_G, 1'b1);

    settle();
    program_regs(5'd2, 5'd4, 1'b0);
    write_cfg(REG_UNUSED, 5'd31);
    // falling then flat values: new minima and ties
    send_base(BASE_T, 1'b0);
    send_base(BASE_G, 1'b0);
    send_base(BASE_C, 1'b0);
    send_base(BASE_A, 1'b0);
    send_base(BASE_A, 1'b0);
    send_base(BASE_A, 1'b0);
    send_base(BASE_A, 1'b0);
    send_base(BASE_A, 1'b0);
    // window shrinks mid-sequence
    settle();
    write_cfg(REG_WINDOW_LENGTH, 5'd2);
    send_base(BASE_T, 1'b0);
    send_base(BASE_T, 1'b0);
    send_base(BASE_T, 1'b0);
    send_base(BASE_T, 1'b0);
    send_base(BASE_G, 1'b0);
    send_base(BASE_C, 1'b1);
    // exactly k bases, then one base short of k
    send_base(BASE_A, 1'b0);
    send_base(BASE_T, 1'b1);
    send_base(BASE_G, 1'b1);

    run_random(5'd16, 5'd16, 1'b1, IDLE_SEND_LIGHT, 30, 0);
    run_random(5'd1, 5'd1, 1'b0, IDLE_SEND_LIGHT, 15, 0);
    run_random(KmerLenReset, WindowLenReset, StrandReset, IDLE_SEND_HEAVY, 25, 14);
    // out-of-range lengths clamp
    run_random(5'd0, 5'd31, 1'b0, IDLE_SEND_HEAVY, 15, 0);
    run_random(5'd3, 5'd5, 1'b1, IDLE_NONE, 20, 0);

    hold_off();
    repeat (SettleCycles) @(posedge clk_i);
    if (board.fails == 0 && board.pending_count() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

FILE: sim.f
hw/rtl/kwm_pkg.sv
hw/rtl/kwm_if.sv
hw/rtl/kwm_cell.sv
hw/rtl/kwm_window.sv
hw/rtl/kmer_window_minimizer.sv
tb/testbench.sv
